FILE: rtl/mbag_pkg.sv
// Shared types, constants and the control store of the multiset bag table.
// Used by the channel interfaces, the sequencer and the top level; depends on nothing.
`default_nettype none

package mbag_pkg;

  // Field widths of the request and result channels.
  localparam int CMD_W = 2;
  localparam int VAL_W = 32;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;

  // Value returned by a read whose index is out of range.
  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd9999;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 2'd0,
    CMD_ERASE_ONE = 2'd1,
    CMD_ERASE_ALL = 2'd2,
    CMD_READ      = 2'd3
  } cmd_e;

  // Sequencer step numbers.
  typedef logic [3:0] step_t;
  localparam step_t STEP_IDLE    = 4'd0;
  localparam step_t STEP_INS     = 4'd1;
  localparam step_t STEP_INS_WR  = 4'd2;
  localparam step_t STEP_RD      = 4'd3;
  localparam step_t STEP_SC_TEST = 4'd4;
  localparam step_t STEP_SC_CMP  = 4'd5;
  localparam step_t STEP_SC_HIT  = 4'd6;
  localparam step_t STEP_SC_MOVE = 4'd7;
  localparam step_t STEP_EMIT    = 4'd8;

  // Branch conditions.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_FULL,
    COND_PTR_END,
    COND_MISS,
    COND_ERASE_ALL,
    COND_OUT_FREE
  } cond_e;

  // Memory read address select.
  typedef enum logic [1:0] {
    RD_NONE,
    RD_PTR,
    RD_LAST,
    RD_IDX
  } rd_sel_e;

  // Memory write select.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_AT_CNT,
    WR_AT_PTR
  } wr_sel_e;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_CLEAR,
    PTR_INC_TAKEN
  } ptr_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef enum logic [1:0] {
    OK_HOLD,
    OK_CLEAR,
    OK_SET,
    OK_IDX
  } ok_op_e;

  // One control word of the program.
  typedef struct packed {
    logic    accept;   // step takes a new request
    logic    disp;     // taken branch goes to the command's routine
    logic    stay;     // untaken branch repeats this step
    logic    emit;     // taken branch loads the result register
    cond_e   cond;
    step_t   target;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    ptr_op_e ptr_op;
    cnt_op_e cnt_op;
    ok_op_e  ok_op;
  } ctrl_word_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic in_valid;
    cmd_e cmd;
    logic full;
    logic ptr_end;
    logic miss;
    logic out_free;
  } seq_status_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    ctrl_word_t cw;
    logic       taken;
  } seq_ctrl_t;

  function automatic ctrl_word_t cw(input logic accept, input logic disp,
                                    input logic stay, input logic emit,
                                    input cond_e cond, input step_t target,
                                    input rd_sel_e rd, input wr_sel_e wr,
                                    input ptr_op_e p, input cnt_op_e c,
                                    input ok_op_e o);
    ctrl_word_t w;
    w.accept = accept;
    w.disp   = disp;
    w.stay   = stay;
    w.emit   = emit;
    w.cond   = cond;
    w.target = target;
    w.rd_sel = rd;
    w.wr_sel = wr;
    w.ptr_op = p;
    w.cnt_op = c;
    w.ok_op  = o;
    return w;
  endfunction

  // The program. Erase scans slot by slot; a hit pulls the last entry into
  // the slot, and erase-all examines that slot again.
  function automatic ctrl_word_t rom_word(input step_t step);
    ctrl_word_t w;
    case (step)
      STEP_IDLE:    w = cw(1'b1, 1'b1, 1'b1, 1'b0, COND_IN_VALID, STEP_IDLE,
                           RD_NONE, WR_NONE, PTR_CLEAR, CNT_HOLD, OK_CLEAR);
      STEP_INS:     w = cw(1'b0, 1'b0, 1'b0, 1'b0, COND_FULL, STEP_EMIT,
                           RD_NONE, WR_NONE, PTR_HOLD, CNT_HOLD, OK_HOLD);
      STEP_INS_WR:  w = cw(1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_EMIT,
                           RD_NONE, WR_AT_CNT, PTR_HOLD, CNT_INC, OK_SET);
      STEP_RD:      w = cw(1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_EMIT,
                           RD_IDX, WR_NONE, PTR_HOLD, CNT_HOLD, OK_IDX);
      STEP_SC_TEST: w = cw(1'b0, 1'b0, 1'b0, 1'b0, COND_PTR_END, STEP_EMIT,
                           RD_PTR, WR_NONE, PTR_HOLD, CNT_HOLD, OK_HOLD);
      STEP_SC_CMP:  w = cw(1'b0, 1'b0, 1'b0, 1'b0, COND_MISS, STEP_SC_TEST,
                           RD_NONE, WR_NONE, PTR_INC_TAKEN, CNT_HOLD, OK_HOLD);
      STEP_SC_HIT:  w = cw(1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_SC_MOVE,
                           RD_LAST, WR_NONE, PTR_HOLD, CNT_DEC, OK_SET);
      STEP_SC_MOVE: w = cw(1'b0, 1'b0, 1'b0, 1'b0, COND_ERASE_ALL, STEP_SC_TEST,
                           RD_NONE, WR_AT_PTR, PTR_HOLD, CNT_HOLD, OK_HOLD);
      STEP_EMIT:    w = cw(1'b0, 1'b0, 1'b1, 1'b1, COND_OUT_FREE, STEP_IDLE,
                           RD_NONE, WR_NONE, PTR_HOLD, CNT_HOLD, OK_HOLD);
      default:      w = cw(1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_IDLE,
                           RD_NONE, WR_NONE, PTR_HOLD, CNT_HOLD, OK_HOLD);
    endcase
    return w;
  endfunction

  // Entry step of each command's routine.
  function automatic step_t disp_target(input cmd_e cmd);
    step_t s;
    case (cmd)
      CMD_INSERT:    s = STEP_INS;
      CMD_ERASE_ONE: s = STEP_SC_TEST;
      CMD_ERASE_ALL: s = STEP_SC_TEST;
      CMD_READ:      s = STEP_RD;
      default:       s = STEP_IDLE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mbag_if.sv
// Request and result channel interfaces of the multiset bag table.
// Depends on mbag_pkg for the field widths.
`default_nettype none

interface mbag_in_if;
  import mbag_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [VAL_W-1:0] operand_value;
  logic [IDX_W-1:0]        read_index;

  modport source (output valid, output command, output operand_value,
                  output read_index, input ready);
  modport sink   (input valid, input command, input operand_value,
                  input read_index, output ready);
endinterface

interface mbag_out_if;
  import mbag_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    ok;
  logic signed [VAL_W-1:0] read_value;
  logic [CNT_W-1:0]        count;

  modport source (output valid, output ok, output read_value, output count,
                  input ready);
  modport sink   (input valid, input ok, input read_value, input count,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/mbag_seq.sv
// Microcode sequencer of the multiset bag table: step counter, program store
// lookup and branch logic. Depends on mbag_pkg.
`default_nettype none

module mbag_seq (
  input  wire                  clk,
  input  wire                  rst_n,
  input  mbag_pkg::seq_status_t status,
  output mbag_pkg::seq_ctrl_t   ctrl
);
  import mbag_pkg::*;

  step_t      step_r;
  step_t      step_nxt;
  ctrl_word_t word;
  logic       taken;

  // Fetch the control word of the current step.
  assign word = rom_word(step_r);

  // Evaluate the branch condition.
  always_comb begin
    case (word.cond)
      COND_ALWAYS:    taken = 1'b1;
      COND_IN_VALID:  taken = status.in_valid;
      COND_FULL:      taken = status.full;
      COND_PTR_END:   taken = status.ptr_end;
      COND_MISS:      taken = status.miss;
      COND_ERASE_ALL: taken = (status.cmd == CMD_ERASE_ALL);
      COND_OUT_FREE:  taken = status.out_free;
      default:        taken = 1'b0;
    endcase
  end

  // Next step: branch target, dispatch by command, hold or fall through.
  always_comb begin
    if (taken) begin
      step_nxt = word.disp ? disp_target(status.cmd) : word.target;
    end else if (word.stay) begin
      step_nxt = step_r;
    end else begin
      step_nxt = step_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctrl = '{cw: word, taken: taken};

endmodule

`default_nettype wire

FILE: rtl/multiset_bag_table.sv
// Top level of the multiset bag table: entry memory, fill count, scan datapath
// and result register. Depends on mbag_pkg, mbag_if and mbag_seq.
//
// An unordered multiset of up to DEPTH signed 32-bit values held in one
// single-port-write, registered-read memory. A request is taken only while the
// sequencer sits idle; each gives one result (ok, read_value, count) held in an
// output register until taken, and the next request may be taken while it
// waits. Insert appends the value at the fill count unless the store is full,
// and read registers the entry at its index. Erase walks the entries from
// slot 0 through the memory's one read port, reading and then comparing each
// slot examined; each entry removed is overwritten with the last entry, read
// and then written into its slot, and erase-one stops at its match. No clearing
// pass is needed after reset: slots at or past the fill count reach no result.
`default_nettype none

module multiset_bag_table #(
  parameter int DEPTH = 1024
) (
  input  wire clk,
  input  wire rst_n,
  mbag_in_if.sink    in_ch,
  mbag_out_if.source out_ch
);
  import mbag_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // Entry memory.
  logic signed [VAL_W-1:0] mem [DEPTH];

  // Request registers.
  cmd_e                    cmd_r;
  logic signed [VAL_W-1:0] val_r;
  logic [XW-1:0]           idx_r;

  // Scan datapath.
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           ptr_r, ptr_nxt;
  logic                    ok_r, ok_nxt;
  logic signed [VAL_W-1:0] rdat_r;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic signed [VAL_W-1:0] wr_data;
  logic [CW-1:0]           last_slot;

  // Result register.
  logic                    out_valid_r;
  logic                    out_ok_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic [CW-1:0]           out_count_r;

  seq_status_t status;
  seq_ctrl_t   ctrl;
  logic        accept;
  logic        emit;
  logic        out_free;

  mbag_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  assign in_ch.ready = ctrl.cw.accept;
  assign accept      = in_ch.valid && ctrl.cw.accept;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign emit        = ctrl.cw.emit && ctrl.taken;
  assign last_slot   = cnt_r - CW'(1);

  // Status toward the sequencer; the idle step dispatches on the live command.
  always_comb begin
    status.in_valid = in_ch.valid;
    status.cmd      = ctrl.cw.accept ? cmd_e'(in_ch.command) : cmd_r;
    status.full     = (cnt_r == FULL_CNT);
    status.ptr_end  = (ptr_r >= cnt_r);
    status.miss     = (rdat_r != val_r);
    status.out_free = out_free;
  end

  // Capture the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_e'(in_ch.command);
      val_r <= in_ch.operand_value;
      idx_r <= XW'(in_ch.read_index);
    end
  end

  // Memory address and data selection.
  always_comb begin
    case (ctrl.cw.rd_sel)
      RD_PTR:  rd_addr = ptr_r[AW-1:0];
      RD_LAST: rd_addr = last_slot[AW-1:0];
      RD_IDX:  rd_addr = idx_r[AW-1:0];
      default: rd_addr = '0;
    endcase
    case (ctrl.cw.wr_sel)
      WR_AT_CNT: begin
        wr_addr = cnt_r[AW-1:0];
        wr_data = val_r;
      end
      default: begin
        wr_addr = ptr_r[AW-1:0];
        wr_data = rdat_r;
      end
    endcase
  end

  // Entry memory with registered read.
  always_ff @(posedge clk) begin
    if (ctrl.cw.wr_sel != WR_NONE) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.cw.rd_sel != RD_NONE) begin
      rdat_r <= mem[rd_addr];
    end
  end

  // Count, scan pointer and ok flag updates.
  always_comb begin
    case (ctrl.cw.cnt_op)
      CNT_INC: cnt_nxt = cnt_r + CW'(1);
      CNT_DEC: cnt_nxt = last_slot;
      default: cnt_nxt = cnt_r;
    endcase
    case (ctrl.cw.ptr_op)
      PTR_CLEAR:     ptr_nxt = '0;
      PTR_INC_TAKEN: ptr_nxt = ctrl.taken ? ptr_r + CW'(1) : ptr_r;
      default:       ptr_nxt = ptr_r;
    endcase
    case (ctrl.cw.ok_op)
      OK_CLEAR: ok_nxt = 1'b0;
      OK_SET:   ok_nxt = 1'b1;
      OK_IDX:   ok_nxt = (idx_r < XW'(cnt_r));
      default:  ok_nxt = ok_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
      ok_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ptr_r <= ptr_nxt;
      ok_r  <= ok_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ok_r    <= ok_r;
      out_count_r <= cnt_r;
      if (cmd_r == CMD_READ) begin
        out_value_r <= ok_r ? rdat_r : MISS_VALUE;
      end else begin
        out_value_r <= '0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = out_ok_r;
  assign out_ch.read_value = out_value_r;
  assign out_ch.count      = CNT_W'(out_count_r);

  // The fill count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("fill count above capacity");

  // The scan pointer never runs past the fill count.
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= cnt_r)
    else $error("scan pointer beyond fill count");

  // An append is only written into a free slot.
  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.cw.wr_sel == WR_AT_CNT) |-> (cnt_r < FULL_CNT))
    else $error("append into a full store");

  // The block is busy right after it takes a request.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("request taken while a command is in progress");

  // The count moves by at most one entry per cycle.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |->
      ((cnt_r == $past(cnt_r) + CW'(1)) || (cnt_r == $past(cnt_r) - CW'(1))))
    else $error("fill count jumped");

endmodule

`default_nettype wire
